[rtl/core/vlc_pkg.sv]
`timescale 1ns / 1ps
package vlc_pkg;

   localparam int SAMPLE_BITS_DEF = 10;
   localparam int CFG_W           = 10;
   localparam int HOLD_W          = 9;
   localparam int COUNT_W         = 8;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 10;
   localparam int RSP_DATA_W      = 8;

   localparam logic [CFG_W-1:0]   LIGHT_THR_RST  = 10'd150;
   localparam logic [CFG_W-1:0]   MOTION_THR_RST = 10'd12;
   localparam logic [HOLD_W-1:0]  HOLD_RST       = 9'd300;
   localparam logic [CFG_W-1:0]   BRAKE_RST      = 10'd512;
   localparam logic [CFG_W-1:0]   RANGE_RST      = 10'd70;

   localparam logic [COUNT_W-1:0] BLINK_TICKS    = 8'd250;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIGHT_THR  = 3'd0,
      CSR_MOTION_THR = 3'd1,
      CSR_HOLD       = 3'd2,
      CSR_BRAKE      = 3'd3,
      CSR_RANGE      = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [CFG_W-1:0]  light_threshold;
      logic [CFG_W-1:0]  motion_threshold;
      logic [HOLD_W-1:0] motion_hold_ticks;
      logic [CFG_W-1:0]  brake_level;
      logic [CFG_W-1:0]  range_limit;
   } cfg_type;

   typedef struct packed {
      logic buzzer;
      logic warning_light;
      logic left_lamp;
      logic right_lamp;
      logic brake_light;
      logic headlight;
   } result_type;

   typedef struct packed {
      logic               active;
      logic [COUNT_W-1:0] count;
   } turn_type;

   // blink windows of the 250-tick pattern
   function automatic logic in_window(input logic [COUNT_W-1:0] c);
      in_window = (c > 8'd0   && c <= 8'd50)  ||
                  (c > 8'd100 && c <  8'd150) ||
                  (c > 8'd200 && c <= 8'd250);
   endfunction

   function automatic turn_type turn_step(input turn_type cur, input logic button,
                                          input logic other_active);
      turn_type nxt;
      nxt = cur;
      if (button && !cur.active && !other_active) begin
         nxt.count  = BLINK_TICKS;
         nxt.active = 1'b1;
      end
      if (nxt.count != '0 && nxt.active) begin
         nxt.count = nxt.count - COUNT_W'(1);
      end else if (nxt.count == '0) begin
         nxt.active = 1'b0;
      end
      turn_step = nxt;
   endfunction

endpackage

[rtl/core/vlc_csr_regs.sv]
`timescale 1ns / 1ps
module vlc_csr_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [vlc_pkg::CSR_IDX_W-1:0]  wr_index,
   input  logic [vlc_pkg::CSR_DATA_W-1:0] wr_data,
   output vlc_pkg::cfg_type               cfg
);
   import vlc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_LIGHT_THR:  cfg_in.light_threshold   = wr_data[CFG_W-1:0];
            CSR_MOTION_THR: cfg_in.motion_threshold  = wr_data[CFG_W-1:0];
            CSR_HOLD:       cfg_in.motion_hold_ticks = wr_data[HOLD_W-1:0];
            CSR_BRAKE:      cfg_in.brake_level       = wr_data[CFG_W-1:0];
            CSR_RANGE:      cfg_in.range_limit       = wr_data[CFG_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light_threshold   <= LIGHT_THR_RST;
         cfg_ff.motion_threshold  <= MOTION_THR_RST;
         cfg_ff.motion_hold_ticks <= HOLD_RST;
         cfg_ff.brake_level       <= BRAKE_RST;
         cfg_ff.range_limit       <= RANGE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/vlc_tick_core.sv]
`timescale 1ns / 1ps
module vlc_tick_core #(
   parameter int SAMPLE_BITS = vlc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  vlc_pkg::cfg_type       cfg,
   input  logic [SAMPLE_BITS-1:0] tilt_x,
   input  logic [SAMPLE_BITS-1:0] tilt_y,
   input  logic [SAMPLE_BITS-1:0] light_level,
   input  logic [SAMPLE_BITS-1:0] rear_range,
   input  logic                   right_button,
   input  logic                   left_button,
   output vlc_pkg::result_type    result
);
   import vlc_pkg::*;

   localparam int CMP_W = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;

   logic                   night_ff, night_in;
   logic [HOLD_W-1:0]      motion_ff, motion_in;
   logic [SAMPLE_BITS-1:0] last_x_ff, last_y_ff;
   turn_type               right_ff, right_in, left_ff, left_in;
   logic [SAMPLE_BITS:0]   beep_ff, beep_in;
   logic [SAMPLE_BITS-1:0] half_ff, half_in;
   logic                   armed_ff, armed_in;
   logic                   sonar_ff, sonar_in;
   logic                   bbuzz;
   logic [2:0]             lamp_ff, lamp_in;

   logic [SAMPLE_BITS-1:0] dx, dy;
   logic                   moved;
   logic [HOLD_W-1:0]      motion_mid;
   logic                   armed_mid;
   logic [SAMPLE_BITS+1:0] range3;
   logic [SAMPLE_BITS:0]   beep_mid;
   logic                   head;

   always_comb begin
      night_in = night_ff;
      if (CMP_W'(light_level) > CMP_W'(cfg.light_threshold)) begin
         night_in = 1'b1;
      end else if (motion_ff == '0) begin
         night_in = 1'b0;
      end

      dx = (tilt_x >= last_x_ff) ? tilt_x - last_x_ff : last_x_ff - tilt_x;
      dy = (tilt_y >= last_y_ff) ? tilt_y - last_y_ff : last_y_ff - tilt_y;
      moved = (CMP_W'(dx) > CMP_W'(cfg.motion_threshold)) ||
              (CMP_W'(dy) > CMP_W'(cfg.motion_threshold));
      motion_mid = moved ? cfg.motion_hold_ticks : motion_ff;
      head       = night_in && (motion_mid != '0);
      motion_in  = (motion_mid != '0) ? motion_mid - HOLD_W'(1) : motion_mid;

      // rear beep, warning and sonar hold at the midpoint
      lamp_in   = lamp_ff;
      sonar_in  = sonar_ff;
      armed_mid = armed_ff;
      if (beep_ff == '0) begin
         armed_mid = 1'b0;
      end else if (beep_ff > {1'b0, half_ff}) begin
         sonar_in   = 1'b1;
         lamp_in[2] = 1'b1;
      end else if (beep_ff < {1'b0, half_ff}) begin
         sonar_in   = 1'b0;
         lamp_in[2] = 1'b0;
      end
      range3   = {2'b00, rear_range} + {1'b0, rear_range, 1'b0};
      beep_mid = beep_ff;
      half_in  = half_ff;
      armed_in = armed_mid;
      if (!armed_mid && (CMP_W'(rear_range) < CMP_W'(cfg.range_limit))) begin
         beep_mid = range3[SAMPLE_BITS+1:1];
         half_in  = range3[SAMPLE_BITS+1:2];
         armed_in = 1'b1;
      end
      beep_in = (beep_mid != '0) ? beep_mid - (SAMPLE_BITS+1)'(1) : beep_mid;

      right_in = turn_step(right_ff, right_button, left_ff.active);
      left_in  = turn_step(left_ff, left_button, right_in.active);

      if (in_window(right_in.count)) begin
         lamp_in[0] = 1'b1;
         bbuzz      = 1'b1;
      end else if (in_window(left_in.count)) begin
         lamp_in[1] = 1'b1;
         bbuzz      = 1'b1;
      end else begin
         lamp_in[1:0] = 2'b00;
         bbuzz        = 1'b0;
      end

      result.headlight     = head;
      result.brake_light   = CMP_W'(tilt_y) >= CMP_W'(cfg.brake_level);
      result.right_lamp    = lamp_in[0];
      result.left_lamp     = lamp_in[1];
      result.warning_light = lamp_in[2];
      result.buzzer        = sonar_in || bbuzz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         night_ff  <= 1'b0;
         motion_ff <= '0;
         last_x_ff <= '0;
         last_y_ff <= '0;
         right_ff  <= '0;
         left_ff   <= '0;
         beep_ff   <= '0;
         half_ff   <= '0;
         armed_ff  <= 1'b0;
         sonar_ff  <= 1'b0;
         lamp_ff   <= '0;
      end else if (advance) begin
         night_ff  <= night_in;
         motion_ff <= motion_in;
         last_x_ff <= tilt_x;
         last_y_ff <= tilt_y;
         right_ff  <= right_in;
         left_ff   <= left_in;
         beep_ff   <= beep_in;
         half_ff   <= half_in;
         armed_ff  <= armed_in;
         sonar_ff  <= sonar_in;
         lamp_ff   <= lamp_in;
      end
   end

`ifndef SYNTHESIS
   a_turn_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(right_ff.active && left_ff.active))
      else $error("both turn signals active");
   a_right_count: assert property (@(posedge clock) disable iff (reset)
      (right_ff.count != '0) |-> right_ff.active)
      else $error("right count running while inactive");
   a_left_count: assert property (@(posedge clock) disable iff (reset)
      (left_ff.count != '0) |-> left_ff.active)
      else $error("left count running while inactive");
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(beep_ff) && $stable(motion_ff))
      else $error("timer moved without a request");
`endif

endmodule

[rtl/core/vehicle_light_controller_tick.sv]
`timescale 1ns / 1ps
// rsp_tvalid rises once the accepted request has passed the input register
// and then the result register; a stall on rsp_tready holds it in between
// throughput: one request per cycle while rsp_tready does not stall, set by the
// combinational tick update between the input and result registers
// reset: synchronous, active high; clears all tick state and the pipeline valids
// and loads the configuration registers with their default values
module vehicle_light_controller_tick #(
   parameter int SAMPLE_BITS = vlc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // tilt_x, tilt_y, light_level, rear_range, right_button, left_button, zero pad
   input  logic [((4*SAMPLE_BITS+2+7)/8)*8-1:0]      req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // headlight, brake_light, right_lamp, left_lamp, warning_light, buzzer, zero pad
   output logic [vlc_pkg::RSP_DATA_W-1:0]            rsp_tdata,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [vlc_pkg::CSR_IDX_W-1:0]             csr_index,
   input  logic [vlc_pkg::CSR_DATA_W-1:0]            csr_data
);
   import vlc_pkg::*;

   localparam int SB = SAMPLE_BITS;

   cfg_type    cfg;
   result_type result;
   result_type out_ff;
   logic       in_vld_ff, in_vld_in;
   logic       out_vld_ff, out_vld_in;
   logic       advance;
   logic [SB-1:0] x_ff, y_ff, light_ff, range_ff;
   logic          rbtn_ff, lbtn_ff;

   assign csr_ready  = 1'b1;
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign in_vld_in  = (req_tvalid && req_tready) || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         x_ff     <= req_tdata[SB-1:0];
         y_ff     <= req_tdata[2*SB-1:SB];
         light_ff <= req_tdata[3*SB-1:2*SB];
         range_ff <= req_tdata[4*SB-1:3*SB];
         rbtn_ff  <= req_tdata[4*SB];
         lbtn_ff  <= req_tdata[4*SB+1];
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   vlc_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   vlc_tick_core #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .cfg          (cfg),
      .tilt_x       (x_ff),
      .tilt_y       (y_ff),
      .light_level  (light_ff),
      .rear_range   (range_ff),
      .right_button (rbtn_ff),
      .left_button  (lbtn_ff),
      .result       (result)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-6){1'b0}}, out_ff.buzzer, out_ff.warning_light,
                        out_ff.left_lamp, out_ff.right_lamp, out_ff.brake_light,
                        out_ff.headlight};

endmodule

[test/tb_vehicle_light_controller_tick.sv]
`timescale 1ns / 1ps
module tb_vehicle_light_controller_tick;
   import vlc_pkg::*;

   localparam int SAMPLE_W  = SAMPLE_BITS_DEF;
   localparam int REQ_W     = ((4*SAMPLE_W+2+7)/8)*8;
   localparam int LIMIT     = 200000;
   localparam int HOLD_OFF  = 80;
   localparam int DRAIN     = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   typedef struct packed {
      logic [SAMPLE_W-1:0] tilt_x;
      logic [SAMPLE_W-1:0] tilt_y;
      logic [SAMPLE_W-1:0] light_level;
      logic [SAMPLE_W-1:0] rear_range;
      logic                right_button;
      logic                left_button;
   } tick_type;

   class lamp_scoreboard;
      logic [CFG_W-1:0]   light_thr, motion_thr, brake_lvl, range_lim;
      logic [HOLD_W-1:0]  hold_ticks;
      logic               night, right_active, left_active;
      logic [HOLD_W-1:0]  motion_timer;
      logic [SAMPLE_W-1:0] last_x, last_y;
      logic [COUNT_W-1:0] right_count, left_count;
      logic [SAMPLE_W:0]  beep_timer;
      logic [SAMPLE_W-1:0] beep_half;
      logic               beep_armed, sonar_buzz, button_buzz;
      logic               right_lamp, left_lamp, warn_lamp;
      result_type         expected_lamps[$];
      int                 errors;

      function new();
         light_thr    = LIGHT_THR_RST;
         motion_thr   = MOTION_THR_RST;
         hold_ticks   = HOLD_RST;
         brake_lvl    = BRAKE_RST;
         range_lim    = RANGE_RST;
         night        = 1'b0;
         motion_timer = '0;
         last_x       = '0;
         last_y       = '0;
         right_active = 1'b0;
         left_active  = 1'b0;
         right_count  = '0;
         left_count   = '0;
         beep_timer   = '0;
         beep_half    = '0;
         beep_armed   = 1'b0;
         sonar_buzz   = 1'b0;
         button_buzz  = 1'b0;
         right_lamp   = 1'b0;
         left_lamp    = 1'b0;
         warn_lamp    = 1'b0;
         errors       = 0;
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_LIGHT_THR:  light_thr  = val;
            CSR_MOTION_THR: motion_thr = val;
            CSR_HOLD:       hold_ticks = val[HOLD_W-1:0];
            CSR_BRAKE:      brake_lvl  = val;
            CSR_RANGE:      range_lim  = val;
            default: ;
         endcase
      endfunction

      function logic moved(input logic [SAMPLE_W-1:0] now, input logic [SAMPLE_W-1:0] prev);
         logic [SAMPLE_W-1:0] d;
         d = (now >= prev) ? now - prev : prev - now;
         return d > motion_thr;
      endfunction

      function logic blink_on(input logic [COUNT_W-1:0] c);
         return (c > 0 && c <= 50) || (c > 100 && c < 150) || (c > 200 && c <= 250);
      endfunction

      function void advance_turn(input logic button, input logic other,
                                 inout logic active, inout logic [COUNT_W-1:0] count);
         if (button && !active && !other) begin
            count  = BLINK_TICKS;
            active = 1'b1;
         end
         if (count != 0 && active) begin
            count = count - 1'b1;
         end else if (count == 0) begin
            active = 1'b0;
         end
      endfunction

      function void take_tick(input tick_type t);
         result_type e;
         if (t.light_level > light_thr) begin
            night = 1'b1;
         end else if (motion_timer == 0) begin
            night = 1'b0;
         end
         if (moved(t.tilt_x, last_x) || moved(t.tilt_y, last_y)) begin
            motion_timer = hold_ticks;
         end
         last_x = t.tilt_x;
         last_y = t.tilt_y;
         e.brake_light = (t.tilt_y >= brake_lvl);
         e.headlight   = night && (motion_timer != 0);
         if (motion_timer != 0) begin
            motion_timer = motion_timer - 1'b1;
         end

         // rear beep: upper half of the countdown drives warning and sonar
         if (beep_timer == 0) begin
            beep_armed = 1'b0;
         end else if (beep_timer > beep_half) begin
            sonar_buzz = 1'b1;
            warn_lamp  = 1'b1;
         end else if (beep_timer < beep_half) begin
            sonar_buzz = 1'b0;
            warn_lamp  = 1'b0;
         end
         if (!beep_armed && t.rear_range < range_lim) begin
            beep_timer = (SAMPLE_W+1)'((int'(t.rear_range) * 3) >> 1);
            beep_half  = SAMPLE_W'(beep_timer >> 1);
            beep_armed = 1'b1;
         end
         if (beep_timer != 0) begin
            beep_timer = beep_timer - 1'b1;
         end

         advance_turn(t.right_button, left_active, right_active, right_count);
         advance_turn(t.left_button, right_active, left_active, left_count);
         if (blink_on(right_count)) begin
            right_lamp  = 1'b1;
            button_buzz = 1'b1;
         end else if (blink_on(left_count)) begin
            left_lamp   = 1'b1;
            button_buzz = 1'b1;
         end else begin
            right_lamp  = 1'b0;
            left_lamp   = 1'b0;
            button_buzz = 1'b0;
         end

         e.right_lamp    = right_lamp;
         e.left_lamp     = left_lamp;
         e.warning_light = warn_lamp;
         e.buzzer        = sonar_buzz | button_buzz;
         expected_lamps.push_back(e);
      endfunction

      function void compare_bit(input string name, input logic exp_v, input logic act_v);
         if (exp_v !== act_v) begin
            $error("%s expected %0b actual %0b", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_lamps(input logic [RSP_DATA_W-1:0] data);
         result_type e, a;
         if (expected_lamps.size() == 0) begin
            $error("response with no request outstanding: %h", data);
            errors++;
            return;
         end
         e = expected_lamps.pop_front();
         a = result_type'(data[$bits(result_type)-1:0]);
         compare_bit("headlight", e.headlight, a.headlight);
         compare_bit("brake_light", e.brake_light, a.brake_light);
         compare_bit("right_lamp", e.right_lamp, a.right_lamp);
         compare_bit("left_lamp", e.left_lamp, a.left_lamp);
         compare_bit("warning_light", e.warning_light, a.warning_light);
         compare_bit("buzzer", e.buzzer, a.buzzer);
      endfunction

      function int pending();
         return expected_lamps.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   lamp_scoreboard sb = new();
   int  walk_x, walk_y;
   int  cycle_count = 0;
   bit  hold_off_pending;

   vehicle_light_controller_tick u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_lamps(rsp_tdata);
      end
   end

   // receiver: stretches of always-ready, random and periodic stalls, plus one hold-off stretch when requested
   initial begin
      int n, mode, len;
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         if (hold_off_pending && !hold_done) begin
            rsp_tready <= 1'b0;
            for (n = 0; n < HOLD_OFF; n++) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(10, 60);
            for (n = 0; n < len; n++) begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= 1'($urandom_range(0, 1));
                  default: rsp_tready <= (n % 3 == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   function automatic tick_type mk_tick(input int x, input int y, input int lt, input int rr,
                                        input bit rb, input bit lb);
      tick_type t;
      t.tilt_x       = SAMPLE_W'(x);
      t.tilt_y       = SAMPLE_W'(y);
      t.light_level  = SAMPLE_W'(lt);
      t.rear_range   = SAMPLE_W'(rr);
      t.right_button = rb;
      t.left_button  = lb;
      return t;
   endfunction

   function automatic int clamp_sample(input int v);
      return (v < 0) ? 0 : ((v > 1023) ? 1023 : v);
   endfunction

   // tilt walks in steps near the movement threshold (at most 64), light hovers around the light threshold
   function automatic tick_type gen_tick();
      tick_type t;
      int span, lt;
      span = (sb.motion_thr > 40) ? 64 : int'(sb.motion_thr) + 8;
      if ($urandom_range(0, 9) == 0) begin
         walk_x = $urandom_range(0, 1023);
         walk_y = $urandom_range(0, 1023);
      end else begin
         walk_x = clamp_sample(walk_x + int'($urandom_range(0, 2*span)) - span);
         walk_y = clamp_sample(walk_y + int'($urandom_range(0, 2*span)) - span);
      end
      if ($urandom_range(0, 6) == 0) begin
         lt = $urandom_range(0, 1023);
      end else begin
         lt = clamp_sample(int'(sb.light_thr) + int'($urandom_range(0, 16)) - 8);
      end
      t = mk_tick(walk_x, walk_y, lt, $urandom_range(0, 1023),
                  $urandom_range(0, 39) == 0, $urandom_range(0, 39) == 0);
      if ($urandom_range(0, 4) == 0 && sb.range_lim != 0) begin
         t.rear_range = SAMPLE_W'($urandom_range(0, sb.range_lim - 1));
      end
      return t;
   endfunction

   task automatic send_tick(input tick_type t);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W-4*SAMPLE_W-2){1'b0}}, t.left_button, t.right_button,
                     t.rear_range, t.light_level, t.tilt_y, t.tilt_x};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.take_tick(t);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_reg(idx, val);
   endtask

   task automatic program_regs(input logic [CSR_DATA_W-1:0] lt, input logic [CSR_DATA_W-1:0] mt,
                               input logic [CSR_DATA_W-1:0] ht, input logic [CSR_DATA_W-1:0] bl,
                               input logic [CSR_DATA_W-1:0] rl);
      write_csr(CSR_LIGHT_THR, lt);
      write_csr(CSR_MOTION_THR, mt);
      write_csr(CSR_HOLD, ht);
      write_csr(CSR_BRAKE, bl);
      write_csr(CSR_RANGE, rl);
      write_csr(CSR_SPARE, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_random(input int n);
      int sent, burst_len, gap;
      sent = 0;
      while (sent < n) begin
         burst_len = $urandom_range(1, 24);
         while (burst_len > 0 && sent < n) begin
            send_tick(gen_tick());
            sent++;
            burst_len--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      tick_type plan[$];
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      walk_x           = 512;
      walk_y           = 512;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // zero range, saturated inputs with both buttons, thresholds hit exactly
      plan.push_back(mk_tick(0, 0, 0, 0, 0, 0));
      plan.push_back(mk_tick(1023, 1023, 1023, 1023, 1, 1));
      plan.push_back(mk_tick(1011, 1023, 150, 70, 0, 1));
      plan.push_back(mk_tick(998, 1023, 151, 69, 0, 0));
      plan.push_back(mk_tick(998, 1010, 0, 1023, 0, 0));
      plan.push_back(mk_tick(998, 511, 0, 1023, 0, 0));
      plan.push_back(mk_tick(998, 512, 1023, 1023, 0, 0));
      plan.push_back(mk_tick(985, 512, 0, 1, 0, 1));
      plan.push_back(mk_tick(973, 500, 0, 2, 0, 0));
      plan.push_back(mk_tick(973, 488, 0, 2, 1, 0));
      plan.push_back(mk_tick(341, 682, 341, 682, 1, 0));
      plan.push_back(mk_tick(682, 341, 682, 341, 0, 1));
      plan.push_back(mk_tick(682, 341, 0, 1023, 0, 0));
      for (int i = 0; i < 6; i++) plan.push_back(mk_tick(682, 341, 0, 2, 0, 0));
      plan.push_back(mk_tick(0, 1023, 1023, 0, 0, 0));
      foreach (plan[i]) send_tick(plan[i]);
      req_tvalid <= 1'b0;

      wait_idle();
      program_regs(10'd0, 10'd0, 10'd1023, 10'd0, 10'd1023);
      run_random(126);

      wait_idle();
      program_regs(10'd1023, 10'd1023, 10'd511, 10'd1023, 10'd0);
      run_random(126);

      wait_idle();
      program_regs(CSR_DATA_W'($urandom_range(100, 400)), CSR_DATA_W'($urandom_range(0, 30)),
                   CSR_DATA_W'($urandom_range(0, 80)), CSR_DATA_W'($urandom),
                   CSR_DATA_W'($urandom_range(4, 200)));
      hold_off_pending = 1'b1;
      run_random(126);

      wait_idle();
      program_regs(CSR_DATA_W'($urandom_range(100, 400)), CSR_DATA_W'($urandom_range(0, 30)),
                   CSR_DATA_W'($urandom_range(0, 80)), CSR_DATA_W'($urandom),
                   CSR_DATA_W'($urandom_range(4, 200)));
      run_random(126);

      wait_idle();
      program_regs(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom_range(0, 100)),
                   CSR_DATA_W'($urandom), CSR_DATA_W'($urandom), CSR_DATA_W'($urandom));
      run_random(126);

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[vehicle_light_controller_tick.f]
rtl/core/vlc_pkg.sv
rtl/core/vlc_csr_regs.sv
rtl/core/vlc_tick_core.sv
rtl/core/vehicle_light_controller_tick.sv
test/tb_vehicle_light_controller_tick.sv
